[sv/fqs_pkg.sv]
// Shared types and constants of the searchable first-in first-out queue.
package fqs_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned OP_W   = 2;
   localparam int unsigned ST_W   = 2;
   localparam int unsigned POS_W  = 5;

   typedef enum logic [OP_W-1:0] {
      OP_ENQ    = 2'd0,
      OP_DEQ    = 2'd1,
      OP_PEEK   = 2'd2,
      OP_SEARCH = 2'd3
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_SCAN = 1'b1
   } state_type;

   // Controls broadcast to every cell of the chain
   typedef struct packed {
      logic shift;    // move data one cell towards the head
      logic capture;  // latch the compare against the key
      logic scan;     // move match bits one cell towards the head
   } chain_ctl_type;

   typedef struct packed {
      status_type              status;
      logic signed [DATA_W-1:0] data;
      logic [POS_W-1:0]        position;
      logic                    empty_res;
   } result_type;

endpackage

[sv/fqs_cell.sv]
// One queue cell: a stored entry and its search match bit.
module fqs_cell
   import fqs_pkg::*;
(
   input  logic                     clock,
   input  chain_ctl_type            ctl,
   input  logic                     load_en,
   input  logic                     occupied,
   input  logic signed [DATA_W-1:0] value_in,
   input  logic signed [DATA_W-1:0] next_data,
   input  logic                     next_match,
   output logic signed [DATA_W-1:0] data_out,
   output logic                     match_out
);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;
   logic                     match_ff;
   logic                     match_in;

   always_comb begin
      data_in = data_ff;
      if (load_en) begin
         data_in = value_in;
      end else if (ctl.shift) begin
         data_in = next_data;
      end
   end

   // an empty cell never matches, whatever it holds
   always_comb begin
      match_in = match_ff;
      if (ctl.capture) begin
         match_in = occupied && (data_ff == value_in);
      end else if (ctl.scan) begin
         match_in = next_match;
      end
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= match_in;
   end

   assign data_out  = data_ff;
   assign match_out = match_ff;

endmodule

[sv/fifo_queue_with_search.sv]
// Top level of the searchable first-in first-out queue built as a chain of cells.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+----------------------------------------
//   req     | in        | req_valid / req_stall | req_operation, req_value
//   rsp     | out       | rsp_valid / rsp_stall | rsp_status, rsp_data, rsp_position,
//           |           |                       | rsp_empty_res
//
// Operations: enqueue, dequeue, peek and a search of an empty queue form their result in the
//   cycle the request is taken. A search ends at the first match, or at the last occupied
//   cell when nothing matches: the match bits walk one cell a cycle to the head.
// Reset clears the occupancy, the sequencer and both result slots; the cells are not
//   cleared, so there is no clearing pass and the queue takes requests at once.
// Stalls: results land in an output register backed by one skid slot, so one request is
//   still taken while a result waits; req_stall rises while searching or the skid is full.
module fifo_queue_with_search
   import fqs_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [OP_W-1:0]          req_operation,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [ST_W-1:0]          rsp_status,
   output logic signed [DATA_W-1:0] rsp_data,
   output logic [POS_W-1:0]         rsp_position,
   output logic                     rsp_empty_res
);

   // counts up to DEPTH itself
   localparam int unsigned CW = $clog2(DEPTH + 1);

   // ---------------------------------------------------------------------
   // control state
   // ---------------------------------------------------------------------
   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   scan_cnt_ff, scan_cnt_in;

   // result slots: output register and skid
   logic            out_valid_ff, out_valid_in;
   result_type      out_ff, out_in;
   logic            skid_valid_ff, skid_valid_in;
   result_type      skid_ff, skid_in;

   // result produced this cycle
   logic            res_we;
   result_type      res;

   chain_ctl_type   ctl;
   logic            accept;
   op_type          op;
   logic            scan_last;
   logic [CW-1:0]   pos_cw;
   logic [POS_W+CW-1:0] pos_ext;

   // ---------------------------------------------------------------------
   // chain of cells, cell 0 holds the oldest entry
   // ---------------------------------------------------------------------
   logic signed [DATA_W-1:0] cell_data [DEPTH];
   logic                     cell_match [DEPTH];
   logic signed [DATA_W-1:0] nxt_data [DEPTH];
   logic                     nxt_match [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == DEPTH - 1) begin : g_tail
         assign nxt_data[i]  = '0;
         assign nxt_match[i] = 1'b0;
      end else begin : g_body
         assign nxt_data[i]  = cell_data[i+1];
         assign nxt_match[i] = cell_match[i+1];
      end

      fqs_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .load_en    (accept && (op == OP_ENQ) && (count_ff == CW'(i))),
         .occupied   (CW'(i) < count_ff),
         .value_in   (req_value),
         .next_data  (nxt_data[i]),
         .next_match (nxt_match[i]),
         .data_out   (cell_data[i]),
         .match_out  (cell_match[i])
      );
   end

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------
   assign req_stall = (state_ff != S_IDLE) || skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign op        = op_type'(req_operation);

   // last occupied cell has reached the head
   assign scan_last = (scan_cnt_ff + CW'(1)) == count_ff;

   // 1-based position, cut to the field width
   assign pos_cw  = scan_cnt_ff + CW'(1);
   assign pos_ext = {{POS_W{1'b0}}, pos_cw};

   // ---------------------------------------------------------------------
   // sequencer: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (op == OP_SEARCH) && (count_ff != '0)) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (cell_match[0] || scan_last) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // sequencer: outputs, occupancy and result
   // ---------------------------------------------------------------------
   always_comb begin
      ctl           = '0;
      res_we        = 1'b0;
      res.status    = ST_OK;
      res.data      = '0;
      res.position  = '0;
      count_in      = count_ff;
      scan_cnt_in   = scan_cnt_ff;

      case (state_ff)
         S_IDLE: begin
            scan_cnt_in = '0;
            if (accept) begin
               case (op)
                  OP_ENQ: begin
                     res_we = 1'b1;
                     if (count_ff == CW'(DEPTH)) begin
                        res.status = ST_FULL;   // value dropped
                     end else begin
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_DEQ: begin
                     res_we = 1'b1;
                     if (count_ff == '0) begin
                        res.status = ST_EMPTY;
                     end else begin
                        res.data  = cell_data[0];
                        ctl.shift = 1'b1;
                        count_in  = count_ff - CW'(1);
                     end
                  end
                  OP_PEEK: begin
                     res_we = 1'b1;
                     if (count_ff == '0) begin
                        res.status = ST_EMPTY;
                     end else begin
                        res.data = cell_data[0];
                     end
                  end
                  OP_SEARCH: begin
                     if (count_ff == '0) begin
                        res_we     = 1'b1;
                        res.status = ST_EMPTY;
                     end else begin
                        ctl.capture = 1'b1;   // key compared in every cell at once
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            if (cell_match[0]) begin
               res_we       = 1'b1;
               res.position = pos_ext[POS_W-1:0];
            end else if (scan_last) begin
               res_we     = 1'b1;
               res.status = ST_NOTFOUND;
            end else begin
               ctl.scan    = 1'b1;
               scan_cnt_in = scan_cnt_ff + CW'(1);
            end
         end
         default: ;
      endcase

      res.empty_res = (count_in == '0);
   end

   // ---------------------------------------------------------------------
   // result slots; the skid only fills while the output register is held
   // ---------------------------------------------------------------------
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = res;
            out_valid_in = res_we;
         end
      end else if (res_we) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         scan_cnt_ff   <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         scan_cnt_ff   <= scan_cnt_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_status    = out_ff.status;
   assign rsp_data      = out_ff.data;
   assign rsp_position  = out_ff.position;
   assign rsp_empty_res = out_ff.empty_res;

endmodule

[sv/fqs_chk.sv]
// Port-level checks on the queue's response channel, bound to the top level.
module fqs_chk
   import fqs_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [ST_W-1:0]          rsp_status,
   input logic signed [DATA_W-1:0] rsp_data,
   input logic [POS_W-1:0]         rsp_position,
   input logic                     rsp_empty_res
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response withdrawn while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data) && $stable(rsp_status)
                                 && $stable(rsp_position) && $stable(rsp_empty_res))
      else $error("stalled response changed");

   // an empty queue reports nothing and stays empty
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY) |->
         rsp_empty_res && (rsp_data == '0) && (rsp_position == '0))
      else $error("empty status with data, position or non-empty flag");

   // a full queue cannot be empty afterwards
   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> !rsp_empty_res && (rsp_data == '0))
      else $error("full status inconsistent");

   a_position_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_position != '0) |-> (rsp_status == ST_OK) && (rsp_data == '0))
      else $error("position reported without a successful search");

endmodule

bind fifo_queue_with_search fqs_chk u_fqs_chk (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_status    (rsp_status),
   .rsp_data      (rsp_data),
   .rsp_position  (rsp_position),
   .rsp_empty_res (rsp_empty_res)
);
